// ----- hw/rtl/mbe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mbe_pkg;

  localparam int DW           = 32;
  localparam int PROD_W       = 2 * DW;
  localparam int EXT_W        = PROD_W + 2;
  localparam int COORD_W      = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int GRAY_W       = 8;

  localparam int IMAGE_SIZE_DEF = 128;
  localparam int FRAC_BITS_DEF  = 28;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RE_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IM_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RE_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IM_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd4;

  localparam logic signed [DW-1:0] RE_ORIGIN_RST = -32'sd536870912;
  localparam logic signed [DW-1:0] IM_ORIGIN_RST = -32'sd300647711;
  localparam logic signed [DW-1:0] RE_STEP_RST   = 32'sd5179965;
  localparam logic signed [DW-1:0] IM_STEP_RST   = 32'sd4697620;
  localparam int                   MAX_ITER_RST  = 1000;

  typedef struct packed {
    logic                 esc;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
  } step_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [EXT_W-1:0] v);
    logic [EXT_W-DW:0] top;
    logic signed [DW-1:0] r;
    top = v[EXT_W-1:DW-1];
    if ((&top) || !(|top)) begin
      r = v[DW-1:0];
    end else if (v[EXT_W-1]) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mbe_cmul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mbe_cmul import mbe_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [DW-1:0]     a0,
  input  wire logic signed [DW-1:0]     b0,
  input  wire logic signed [DW-1:0]     a1,
  input  wire logic signed [DW-1:0]     b1,
  input  wire logic signed [DW-1:0]     a2,
  input  wire logic signed [DW-1:0]     b2,
  output logic signed [PROD_W-1:0]      p0,
  output logic signed [PROD_W-1:0]      p1,
  output logic signed [PROD_W-1:0]      p2
);

  always_ff @(posedge clk) begin
    p0 <= PROD_W'(a0) * PROD_W'(b0);
    p1 <= PROD_W'(a1) * PROD_W'(b1);
    p2 <= PROD_W'(a2) * PROD_W'(b2);
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mbe_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mbe_step import mbe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic signed [PROD_W-1:0] p_xx,
  input  wire logic signed [PROD_W-1:0] p_yy,
  input  wire logic signed [PROD_W-1:0] p_xy,
  input  wire logic signed [DW-1:0]     c_re,
  input  wire logic signed [DW-1:0]     c_im,
  output step_t                         res
);

  localparam int THR_W = 2 * FRAC_BITS + 3;
  localparam int CMP_W = (THR_W > PROD_W + 1) ? THR_W : PROD_W + 1;
  localparam logic [CMP_W-1:0] THRESH = {{(CMP_W-3){1'b0}}, 3'd4} << (2 * FRAC_BITS);

  logic [PROD_W:0]          mag;
  logic signed [PROD_W-1:0] diff;
  logic signed [PROD_W-1:0] sh_re;
  logic signed [PROD_W-1:0] sh_im;

  always_comb begin
    // squares are non-negative, so the sum is taken unsigned
    mag   = {1'b0, p_xx} + {1'b0, p_yy};
    diff  = p_xx - p_yy;
    sh_re = diff >>> FRAC_BITS;
    sh_im = p_xy >>> (FRAC_BITS - 1);
    res.esc = CMP_W'(mag) > THRESH;
    res.x   = sat32(EXT_W'(sh_re) + EXT_W'(c_re));
    res.y   = sat32(EXT_W'(sh_im) + EXT_W'(c_im));
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mandelbrot_escape_time.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Mandelbrot escape-time unit, signed Q4.28 fixed point.
//
// Command channel: pixel_col/pixel_row are taken at a rising edge with start
// high and busy low. busy stays high until the pixel is finished.
// Result channel: done is high for exactly one cycle with iteration_count and
// gray_level (count modulo 256). The receiver cannot stall; there is no hold.
// Config: cfg_we/cfg_index/cfg_data write re_origin, im_origin, re_step,
// im_step, max_iterations (indices 0..4); other indices are ignored. Write
// only while busy is low.
//
// Timing: each z = z*z + c step passes through S_MUL (registered products from
// the three-multiplier unit) and then S_UPD (escape test and update). A taken
// pixel first passes S_MAP and S_ORG, which form c, then repeats the step until
// it escapes or reaches the limit. A new start can be taken at the edge that
// ends the done cycle; one pixel is worked on at a time.
// Reset: synchronous rst returns the sequencer to idle, drops done and loads
// the default view and an iteration limit of 1000.
module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int IMAGE_SIZE = IMAGE_SIZE_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_W-1:0]    pixel_col,
  input  wire logic [COORD_W-1:0]    pixel_row,
  output logic                       done,
  output logic [COUNT_BITS-1:0]      iteration_count,
  output logic [GRAY_W-1:0]          gray_level,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [DW-1:0]         cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_ORG,
    S_MUL,
    S_UPD
  } state_t;

  state_t state;

  logic signed [DW-1:0]   re_origin;
  logic signed [DW-1:0]   im_origin;
  logic signed [DW-1:0]   re_step;
  logic signed [DW-1:0]   im_step;
  logic [COUNT_BITS-1:0]  max_iterations;

  logic [COORD_W-1:0]     col;
  logic [COORD_W-1:0]     row;
  logic signed [DW-1:0]   c_re;
  logic signed [DW-1:0]   c_im;
  logic signed [DW-1:0]   x;
  logic signed [DW-1:0]   y;
  logic [COUNT_BITS-1:0]  count;

  logic [COORD_W-1:0]     col_next;
  logic [COORD_W-1:0]     row_next;
  logic signed [DW-1:0]   a0;
  logic signed [DW-1:0]   b0;
  logic signed [DW-1:0]   a1;
  logic signed [DW-1:0]   b1;
  logic signed [PROD_W-1:0] p0;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;
  step_t                  res;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      re_origin      <= RE_ORIGIN_RST;
      im_origin      <= IM_ORIGIN_RST;
      re_step        <= RE_STEP_RST;
      im_step        <= IM_STEP_RST;
      max_iterations <= COUNT_BITS'(MAX_ITER_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RE_ORIGIN: re_origin      <= cfg_data;
        REG_IM_ORIGIN: im_origin      <= cfg_data;
        REG_RE_STEP:   re_step        <= cfg_data;
        REG_IM_STEP:   im_step        <= cfg_data;
        REG_MAX_ITER:  max_iterations <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_next = (32'(pixel_col) >= 32'(IMAGE_SIZE)) ? COORD_W'(IMAGE_SIZE - 1) : pixel_col;
    row_next = (32'(pixel_row) >= 32'(IMAGE_SIZE)) ? COORD_W'(IMAGE_SIZE - 1) : pixel_row;
    if (state == S_MAP) begin
      a0 = signed'(DW'(col));
      b0 = re_step;
      a1 = signed'(DW'(row));
      b1 = im_step;
    end else begin
      a0 = x;
      b0 = x;
      a1 = y;
      b1 = y;
    end
  end

  mbe_cmul u_cmul (
    .clk (clk),
    .a0  (a0),
    .b0  (b0),
    .a1  (a1),
    .b1  (b1),
    .a2  (x),
    .b2  (y),
    .p0  (p0),
    .p1  (p1),
    .p2  (p2)
  );

  mbe_step #(
    .FRAC_BITS (FRAC_BITS)
  ) u_step (
    .p_xx (p0),
    .p_yy (p1),
    .p_xy (p2),
    .c_re (c_re),
    .c_im (c_im),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            col   <= col_next;
            row   <= row_next;
            state <= S_MAP;
          end
        end
        S_MAP: begin
          state <= S_ORG;
        end
        S_ORG: begin
          c_re  <= sat32(EXT_W'(re_origin) + EXT_W'(p0));
          c_im  <= sat32(EXT_W'(im_origin) + EXT_W'(p1));
          x     <= '0;
          y     <= '0;
          count <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (count >= max_iterations || res.esc) begin
            done            <= 1'b1;
            iteration_count <= count;
            gray_level      <= GRAY_W'(count);
            state           <= S_IDLE;
          end else begin
            x     <= res.x;
            y     <= res.y;
            count <= count + 1'b1;
            state <= S_MUL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_gray: assert property (@(posedge clk) disable iff (rst)
    done |-> gray_level == GRAY_W'(iteration_count))
    else $error("gray level differs from count");

  a_limit: assert property (@(posedge clk) disable iff (rst)
    done |-> iteration_count <= max_iterations)
    else $error("count beyond limit");

  a_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("start not taken");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD && !(count >= max_iterations || res.esc) |=> count == $past(count) + 1'b1)
    else $error("count step wrong");

endmodule
`default_nettype wire
